[hw/rtl/segment_packet_deframer_top_defines.svh]
// Assertion macros for the segment packet deframer checker.
// Used by the checker file only; needs clk and rst_n in scope.
`ifndef SEGMENT_PACKET_DEFRAMER_TOP_DEFINES_SVH
`define SEGMENT_PACKET_DEFRAMER_TOP_DEFINES_SVH

// same-cycle implication
`define SPD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m failed");

// next-cycle implication
`define SPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m failed");

`endif

[hw/rtl/spd_pkg.sv]
// Package for the segment packet deframer: constants, status codes, payload types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spd_pkg;

    localparam int DGRAM_LIMIT        = 65536;
    localparam int CNT_W              = $clog2(DGRAM_LIMIT + 2);
    localparam int HDR_LEN            = 28;
    localparam int SEG_LEN            = 16;
    localparam int SEG_K_W            = $clog2(SEG_LEN);
    localparam int SEG_IDX_W          = CNT_W - SEG_K_W;
    localparam int EXPECT_W           = 32 + SEG_K_W + 1;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_MAGIC   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_VERSION = 1'b1;

    localparam logic KIND_SEGMENT = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_SHORT_HDR  = 4'd1,
        ST_MAGIC      = 4'd2,
        ST_VERSION    = 4'd3,
        ST_HDR_SIZE   = 4'd4,
        ST_ZERO_COUNT = 4'd5,
        ST_INDEX      = 4'd6,
        ST_SHORT_DATA = 4'd7,
        ST_TRAILING   = 4'd8,
        ST_OVERSIZE   = 4'd9
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } spd_in_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] x_start_bits;
        logic [31:0] y_start_bits;
        logic [31:0] x_end_bits;
        logic [31:0] y_end_bits;
        logic [63:0] seq_number;
        logic [31:0] packet_number;
        logic [31:0] packet_total;
        logic [31:0] segment_total;
        logic [3:0]  status;
    } spd_out_t;

endpackage

`default_nettype wire

[hw/rtl/segment_packet_deframer_top.sv]
// Segment packet deframer top level: header capture, segment assembly, result queue.
// Depends on spd_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall / in_item) carries one datagram byte per
//   transaction, last_byte set on the final byte. Output channel (out_valid /
//   out_stall / out_result) carries segment results (kind 0) and one status
//   result (kind 1) after each datagram. Drop a datagram's segments when its
//   status is not 0.
//   Each accepted byte is handled in the cycle it is accepted; its results are
//   written into a 4-entry result queue and shown on the output from its head.
//   Throughput is one byte per cycle while in_stall is low; a byte may give two
//   results (last segment plus status), which drain one per cycle if not stalled.
//   in_stall rises while the queue holds 3 or more results, so a stalled
//   receiver backs up into the input after at most 3 queued results.
//   Config (cfg_wr_en / cfg_index / cfg_wdata) writes magic word (index 0) and
//   expected version (index 1); write only while the block is idle.
//   Reset empties the queue, clears datagram state, sets magic 0, version 1.
`timescale 1ns / 1ps
`default_nettype none

module segment_packet_deframer_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire spd_pkg::spd_in_t             in_item,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output spd_pkg::spd_out_t                 out_result,
    input  wire logic                         cfg_wr_en,
    input  wire logic [spd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [spd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    import spd_pkg::*;

    logic [31:0]      magic_word_reg;
    logic [15:0]      exp_version_reg;

    logic [CNT_W-1:0] byte_cnt_reg,   byte_cnt_next;
    logic [31:0]      magic_seen_reg, magic_seen_next;
    logic [15:0]      version_reg,    version_next;
    logic [15:0]      hdr_size_reg,   hdr_size_next;
    logic [63:0]      sequence_reg,   sequence_next;
    logic [31:0]      index_reg,      index_next;
    logic [31:0]      count_reg,      count_next;
    logic [31:0]      declared_reg,   declared_next;

    logic [CNT_W-1:0] cnt_cap;
    logic [31:0]      magic_cap;
    logic [15:0]      version_cap;
    logic [15:0]      hdr_size_cap;
    logic [63:0]      sequence_cap;
    logic [31:0]      index_cap;
    logic [31:0]      count_cap;
    logic [31:0]      declared_cap;

    logic [7:0]       seg_buf_reg [SEG_LEN-1];

    spd_out_t         fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FCNT_W-1:0] fcnt_reg,  fcnt_next;

    logic             accept;
    logic             pop;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] body_off;
    logic [SEG_K_W-1:0]   seg_k;
    logic [SEG_IDX_W-1:0] seg_idx;
    logic             in_body;
    logic             hdr_ok;
    logic             seg_emit;
    logic [7:0]       b;
    status_t          status_val;
    logic [EXPECT_W-1:0] expect_len;
    logic [EXPECT_W-1:0] n_ext;
    spd_out_t         seg_res;
    spd_out_t         stat_res;
    spd_out_t         entry0;
    logic             push0;
    logic             push1;
    logic [1:0]       push_n;

    assign accept = in_valid && !in_stall;
    assign pop    = out_valid && !out_stall;
    assign b      = in_item.data_byte;
    assign pos    = byte_cnt_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_word_reg  <= '0;
            exp_version_reg <= 16'd1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_MAGIC:   magic_word_reg  <= cfg_wdata;
                REG_VERSION: exp_version_reg <= cfg_wdata[15:0];
                default:     ;
            endcase
        end
    end

    // header capture
    always_comb
    begin
        cnt_cap      = byte_cnt_reg;
        magic_cap    = magic_seen_reg;
        version_cap  = version_reg;
        hdr_size_cap = hdr_size_reg;
        sequence_cap = sequence_reg;
        index_cap    = index_reg;
        count_cap    = count_reg;
        declared_cap = declared_reg;
        if (byte_cnt_reg <= CNT_W'(DGRAM_LIMIT))
        begin
            cnt_cap = byte_cnt_reg + CNT_W'(1);
        end
        if (pos < CNT_W'(4))
        begin
            magic_cap[{pos[1:0], 3'b000} +: 8] = b;
        end
        else if (pos < CNT_W'(6))
        begin
            version_cap[{pos[0], 3'b000} +: 8] = b;
        end
        else if (pos < CNT_W'(8))
        begin
            hdr_size_cap[{pos[0], 3'b000} +: 8] = b;
        end
        else if (pos < CNT_W'(16))
        begin
            sequence_cap[{pos[2:0], 3'b000} +: 8] = b;
        end
        else if (pos < CNT_W'(20))
        begin
            index_cap[{pos[1:0], 3'b000} +: 8] = b;
        end
        else if (pos < CNT_W'(24))
        begin
            count_cap[{pos[1:0], 3'b000} +: 8] = b;
        end
        else if (pos < CNT_W'(HDR_LEN))
        begin
            declared_cap[{pos[1:0], 3'b000} +: 8] = b;
        end
    end

    // datagram state update; cleared after the final byte
    always_comb
    begin
        byte_cnt_next   = byte_cnt_reg;
        magic_seen_next = magic_seen_reg;
        version_next    = version_reg;
        hdr_size_next   = hdr_size_reg;
        sequence_next   = sequence_reg;
        index_next      = index_reg;
        count_next      = count_reg;
        declared_next   = declared_reg;
        if (accept)
        begin
            if (in_item.last_byte)
            begin
                byte_cnt_next   = '0;
                magic_seen_next = '0;
                version_next    = '0;
                hdr_size_next   = '0;
                sequence_next   = '0;
                index_next      = '0;
                count_next      = '0;
                declared_next   = '0;
            end
            else
            begin
                byte_cnt_next   = cnt_cap;
                magic_seen_next = magic_cap;
                version_next    = version_cap;
                hdr_size_next   = hdr_size_cap;
                sequence_next   = sequence_cap;
                index_next      = index_cap;
                count_next      = count_cap;
                declared_next   = declared_cap;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_cnt_reg   <= '0;
            magic_seen_reg <= '0;
            version_reg    <= '0;
            hdr_size_reg   <= '0;
            sequence_reg   <= '0;
            index_reg      <= '0;
            count_reg      <= '0;
            declared_reg   <= '0;
        end
        else
        begin
            byte_cnt_reg   <= byte_cnt_next;
            magic_seen_reg <= magic_seen_next;
            version_reg    <= version_next;
            hdr_size_reg   <= hdr_size_next;
            sequence_reg   <= sequence_next;
            index_reg      <= index_next;
            count_reg      <= count_next;
            declared_reg   <= declared_next;
        end
    end

    // segment assembly
    assign body_off = pos - CNT_W'(HDR_LEN);
    assign seg_k    = body_off[SEG_K_W-1:0];
    assign seg_idx  = body_off[CNT_W-1:SEG_K_W];
    assign in_body  = (pos >= CNT_W'(HDR_LEN)) && (pos < CNT_W'(DGRAM_LIMIT));
    assign hdr_ok   = (magic_seen_reg == magic_word_reg)
                   && (version_reg == exp_version_reg)
                   && (hdr_size_reg == 16'(HDR_LEN))
                   && (count_reg != '0)
                   && (index_reg < count_reg);
    assign seg_emit = in_body && (seg_k == SEG_K_W'(SEG_LEN - 1)) && hdr_ok
                   && (32'(seg_idx) < declared_reg);

    always_ff @(posedge clk)
    begin
        if (accept && in_body && (seg_k != SEG_K_W'(SEG_LEN - 1)))
        begin
            seg_buf_reg[seg_k] <= b;
        end
    end

    always_comb
    begin
        seg_res              = '0;
        seg_res.kind         = KIND_SEGMENT;
        seg_res.x_start_bits = {seg_buf_reg[3],  seg_buf_reg[2],  seg_buf_reg[1],  seg_buf_reg[0]};
        seg_res.y_start_bits = {seg_buf_reg[7],  seg_buf_reg[6],  seg_buf_reg[5],  seg_buf_reg[4]};
        seg_res.x_end_bits   = {seg_buf_reg[11], seg_buf_reg[10], seg_buf_reg[9],  seg_buf_reg[8]};
        seg_res.y_end_bits   = {b,               seg_buf_reg[14], seg_buf_reg[13], seg_buf_reg[12]};
    end

    // final status
    assign expect_len = EXPECT_W'(HDR_LEN) + {1'b0, declared_cap, {SEG_K_W{1'b0}}};
    assign n_ext      = EXPECT_W'(cnt_cap);

    always_comb
    begin
        if (cnt_cap < CNT_W'(HDR_LEN))
            status_val = ST_SHORT_HDR;
        else if (magic_cap != magic_word_reg)
            status_val = ST_MAGIC;
        else if (version_cap != exp_version_reg)
            status_val = ST_VERSION;
        else if (hdr_size_cap != 16'(HDR_LEN))
            status_val = ST_HDR_SIZE;
        else if (count_cap == '0)
            status_val = ST_ZERO_COUNT;
        else if (index_cap >= count_cap)
            status_val = ST_INDEX;
        else if (cnt_cap > CNT_W'(DGRAM_LIMIT))
            status_val = ST_OVERSIZE;
        else if (n_ext < expect_len)
            status_val = ST_SHORT_DATA;
        else if (n_ext > expect_len)
            status_val = ST_TRAILING;
        else
            status_val = ST_OK;
    end

    always_comb
    begin
        stat_res        = '0;
        stat_res.kind   = KIND_STATUS;
        stat_res.status = status_val;
        if (status_val != ST_SHORT_HDR)
        begin
            stat_res.seq_number    = sequence_cap;
            stat_res.packet_number = index_cap;
            stat_res.packet_total  = count_cap;
            stat_res.segment_total = declared_cap;
        end
    end

    // result queue
    assign push0  = accept && (seg_emit || in_item.last_byte);
    assign push1  = accept && seg_emit && in_item.last_byte;
    assign entry0 = seg_emit ? seg_res : stat_res;
    assign push_n = {1'b0, push0} + {1'b0, push1};

    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            fifo_reg[wr_ptr_reg] <= entry0;
        end
        if (push1)
        begin
            fifo_reg[wr_ptr_reg + PTR_W'(1)] <= stat_res;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        fcnt_next   = fcnt_reg + FCNT_W'(push_n) - FCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fcnt_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fcnt_reg   <= fcnt_next;
        end
    end

    assign out_valid  = (fcnt_reg != '0);
    assign out_result = fifo_reg[rd_ptr_reg];
    assign in_stall   = (fcnt_reg > FCNT_W'(FIFO_DEPTH - 2));

endmodule

`default_nettype wire

[hw/rtl/spd_checker.sv]
// Port-level checker for the segment packet deframer, bound to the top level.
// Depends on spd_pkg and segment_packet_deframer_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "segment_packet_deframer_top_defines.svh"

module spd_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic                           in_stall,
    input  wire spd_pkg::spd_in_t               in_item,
    input  wire logic                           out_valid,
    input  wire logic                           out_stall,
    input  wire spd_pkg::spd_out_t              out_result
);

    import spd_pkg::*;

    `SPD_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_item))

    `SPD_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(out_result))

    `SPD_ASSERT_IMPL(a_seg_clean, out_valid && (out_result.kind == KIND_SEGMENT),
        (out_result.status == ST_OK) && (out_result.seq_number == '0)
        && (out_result.packet_total == '0) && (out_result.segment_total == '0))

    `SPD_ASSERT_IMPL(a_status_clean, out_valid && (out_result.kind == KIND_STATUS),
        (out_result.x_start_bits == '0) && (out_result.y_end_bits == '0)
        && (out_result.status <= ST_OVERSIZE))

    `SPD_ASSERT_IMPL(a_short_hdr_zero,
        out_valid && (out_result.kind == KIND_STATUS) && (out_result.status == ST_SHORT_HDR),
        (out_result.seq_number == '0) && (out_result.packet_number == '0)
        && (out_result.packet_total == '0) && (out_result.segment_total == '0))

endmodule

bind segment_packet_deframer_top spd_checker u_spd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
);

`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench for segment_packet_deframer_top: datagram table, random datagrams.
// Depends on spd_pkg and segment_packet_deframer_top; results checked by a local deframer model.
`timescale 1ns / 1ps

module tb_top;
    import spd_pkg::*;

    typedef struct packed {
        logic [31:0] magic;
        logic [15:0] ver;
        logic [15:0] hsize;
        logic [63:0] seq;
        logic [31:0] idx;
        logic [31:0] pcount;
        logic [31:0] segs;
        logic [31:0] len;
        logic        known;
        status_t     st;
    } dgram_t;

    // header size taken from the package so the table tracks it
    localparam logic [15:0] HS = 16'(HDR_LEN);

    localparam dgram_t DIRECTED [14] = '{
        '{32'h0, 16'h1, HS, 64'h0, 32'h0, 32'h1, 32'h0, 32'd1, 1'b1, ST_SHORT_HDR},
        '{32'h0, 16'h1, HS, 64'h0, 32'h0, 32'h1, 32'h0, 32'd27, 1'b1, ST_SHORT_HDR},
        '{32'h0, 16'h1, HS, 64'h0, 32'h0, 32'h1, 32'h0, 32'd28, 1'b1, ST_OK},
        '{32'h0, 16'h1, HS, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
          32'd2, 32'd60, 1'b1, ST_OK},
        '{32'h0, 16'h1, HS, 64'h0123_4567_89AB_CDEF, 32'd3, 32'd7, 32'd1, 32'd44,
          1'b0, ST_OK},
        '{32'hFFFF_FFFF, 16'h1, HS, 64'h5, 32'h0, 32'h1, 32'd1, 32'd44, 1'b1, ST_MAGIC},
        '{32'h0, 16'hFFFF, HS, 64'h6, 32'h0, 32'h1, 32'd1, 32'd44, 1'b1, ST_VERSION},
        '{32'h0, 16'h1, 16'hFFFF, 64'h7, 32'h0, 32'h1, 32'd1, 32'd44, 1'b1, ST_HDR_SIZE},
        '{32'h0, 16'h1, HS, 64'h8, 32'h0, 32'h0, 32'd1, 32'd44, 1'b1, ST_ZERO_COUNT},
        '{32'h0, 16'h1, HS, 64'h9, 32'd5, 32'd5, 32'd1, 32'd44, 1'b1, ST_INDEX},
        '{32'h0, 16'h1, HS, 64'hA, 32'h0, 32'h1, 32'd3, 32'd65, 1'b1, ST_SHORT_DATA},
        '{32'h0, 16'h1, HS, 64'hB, 32'h0, 32'h1, 32'd1, 32'd76, 1'b1, ST_TRAILING},
        '{32'h0, 16'h1, HS, 64'hC, 32'h0, 32'h1, 32'd1, 32'd59, 1'b1, ST_TRAILING},
        '{32'h1, 16'h2, 16'h0, 64'hD, 32'h0, 32'h0, 32'd1, 32'd44, 1'b1, ST_MAGIC}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    spd_in_t               in_item = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    spd_out_t              out_result;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // deframer model state
    logic [31:0]      cfg_magic = 32'h0;
    logic [15:0]      cfg_version = 16'h1;
    logic [CNT_W-1:0] byte_cnt = '0;
    logic [223:0]     hdr_seen = '0;
    logic [63:0]      seg_buf [2] = '{64'h0, 64'h0};
    spd_out_t         step_out [2];

    spd_out_t pending_results [$];
    spd_out_t want;
    int       errors = 0;
    int       burst_left = 1;
    int       stall_mode = 0;
    int       mode_left = 0;
    int       run_left = 0;

    segment_packet_deframer_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    always #4 clk = ~clk;

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want_val);
        if (got !== want_val)
            flag_error($sformatf("%s got %h want %h", name, got, want_val));
    endtask

    function automatic status_t header_verdict();
        if (hdr_seen[31:0] != cfg_magic) return ST_MAGIC;
        if (hdr_seen[47:32] != cfg_version) return ST_VERSION;
        if (hdr_seen[63:48] != HDR_LEN) return ST_HDR_SIZE;
        if (hdr_seen[191:160] == 32'h0) return ST_ZERO_COUNT;
        if (hdr_seen[159:128] >= hdr_seen[191:160]) return ST_INDEX;
        return ST_OK;
    endfunction

    // Advances the model by one byte; results land in step_out, count returned.
    function automatic int deframe_byte(input logic [7:0] b, input logic l);
        int          p;
        int unsigned k;
        int unsigned seg;
        logic [36:0] want_len;
        status_t     st;
        spd_out_t    r;
        int          n;
        p = byte_cnt;
        n = 0;
        if (byte_cnt <= DGRAM_LIMIT) byte_cnt = byte_cnt + 1'b1;
        if (p < HDR_LEN) begin
            hdr_seen[8*p +: 8] = b;
        end else if (p < DGRAM_LIMIT) begin
            k = (p - HDR_LEN) % SEG_LEN;
            seg = (p - HDR_LEN) / SEG_LEN;
            seg_buf[k / 8][8 * (k % 8) +: 8] = b;
            if (k == SEG_LEN - 1 && header_verdict() == ST_OK && seg < hdr_seen[223:192])
            begin
                r = '0;
                r.kind = KIND_SEGMENT;
                r.x_start_bits = seg_buf[0][31:0];
                r.y_start_bits = seg_buf[0][63:32];
                r.x_end_bits = seg_buf[1][31:0];
                r.y_end_bits = seg_buf[1][63:32];
                step_out[n] = r;
                n++;
            end
        end
        if (l) begin
            if (byte_cnt < HDR_LEN) begin
                st = ST_SHORT_HDR;
            end else begin
                st = header_verdict();
                want_len = {1'b0, hdr_seen[223:192], 4'b0000} + HDR_LEN;
                if (st == ST_OK) begin
                    if (byte_cnt > DGRAM_LIMIT) st = ST_OVERSIZE;
                    else if (byte_cnt < want_len) st = ST_SHORT_DATA;
                    else if (byte_cnt > want_len) st = ST_TRAILING;
                end
            end
            r = '0;
            r.kind = KIND_STATUS;
            if (st != ST_SHORT_HDR) begin
                r.seq_number = hdr_seen[127:64];
                r.packet_number = hdr_seen[159:128];
                r.packet_total = hdr_seen[191:160];
                r.segment_total = hdr_seen[223:192];
            end
            r.status = st;
            step_out[n] = r;
            n++;
            byte_cnt = '0;
            hdr_seen = '0;
            seg_buf[0] = 64'h0;
            seg_buf[1] = 64'h0;
        end
        return n;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic l, input logic known,
                             input status_t st);
        int n;
        int i;
        int gap;
        in_item <= '{data_byte: b, last_byte: l};
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        n = deframe_byte(b, l);
        if (l && known) step_out[n-1].status = st;
        for (i = 0; i < n; i++) pending_results.insert(pending_results.size(), step_out[i]);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 16);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_datagram(input dgram_t d);
        logic [223:0] hdr;
        logic [7:0]   b;
        int unsigned  i;
        hdr = {d.segs, d.pcount, d.idx, d.seq, d.hsize, d.ver, d.magic};
        for (i = 0; i < d.len; i++) begin
            if (i < HDR_LEN) b = hdr[8*i +: 8];
            else b = 8'($urandom);
            push_byte(b, i == d.len - 1, d.known, d.st);
        end
    endtask

    function automatic dgram_t random_dgram();
        dgram_t d;
        d.magic = cfg_magic;
        d.ver = cfg_version;
        d.hsize = HS;
        d.seq = {$urandom, $urandom};
        d.pcount = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 8);
        d.idx = $urandom_range(0, d.pcount - 1);
        d.segs = $urandom_range(0, 4);
        d.len = HDR_LEN + d.segs * SEG_LEN;
        d.known = 1'b0;
        d.st = ST_OK;
        case ($urandom_range(0, 19))
            0: d.len = $urandom_range(1, HDR_LEN - 1);
            1: d.magic ^= 32'h1 << $urandom_range(0, 31);
            2: d.ver ^= 16'h1 << $urandom_range(0, 15);
            3: d.hsize = 16'($urandom);
            4: d.pcount = 32'h0;
            5: d.idx = d.pcount + $urandom_range(0, 2);
            6: d.len = HDR_LEN + $urandom_range(0, 95);
            7: d.len += $urandom_range(1, 40);
            8: d.segs = $urandom;
            9: begin
                d.magic = $urandom;
                d.ver = 16'($urandom);
                d.hsize = 16'($urandom);
                d.len = $urandom_range(1, 80);
            end
            default: ;
        endcase
        return d;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        if (idx == REG_MAGIC) cfg_magic = data;
        else cfg_version = data[15:0];
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                flag_error("result with nothing pending");
            end else begin
                want = pending_results.pop_front();
                compare_field("kind", out_result.kind, want.kind);
                compare_field("x_start_bits", out_result.x_start_bits, want.x_start_bits);
                compare_field("y_start_bits", out_result.y_start_bits, want.y_start_bits);
                compare_field("x_end_bits", out_result.x_end_bits, want.x_end_bits);
                compare_field("y_end_bits", out_result.y_end_bits, want.y_end_bits);
                compare_field("seq_number", out_result.seq_number, want.seq_number);
                compare_field("packet_number", out_result.packet_number, want.packet_number);
                compare_field("packet_total", out_result.packet_total, want.packet_total);
                compare_field("segment_total", out_result.segment_total, want.segment_total);
                compare_field("status", out_result.status, want.status);
            end
        end
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(32, 400);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 2) == 0);
            default: begin
                if (run_left == 0) begin
                    out_stall <= ~out_stall;
                    run_left <= $urandom_range(1, 20);
                end else begin
                    run_left <= run_left - 1;
                end
            end
        endcase
    end

    initial begin
        #40_000_000;
        $display("segment_packet_deframer_top test failed");
        $finish;
    end

    initial begin
        int     ph;
        int     sent;
        dgram_t d;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i]) send_datagram(DIRECTED[i]);
        wait_idle();

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_MAGIC, 32'hFFFF_FFFF);
                    write_reg(REG_VERSION, 32'h0000_FFFF);
                end
                1: begin
                    write_reg(REG_MAGIC, 32'h0);
                    write_reg(REG_VERSION, {16'($urandom), 16'h0});
                end
                default: begin
                    write_reg(REG_MAGIC, $urandom);
                    write_reg(REG_VERSION, $urandom);
                end
            endcase
            sent = 0;
            while (sent < 50) begin
                d = random_dgram();
                send_datagram(d);
                sent += d.len;
            end
            wait_idle();
        end

        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("segment_packet_deframer_top test passed");
        else
            $display("segment_packet_deframer_top test failed");
        $finish;
    end

endmodule
